// ===== sv/spwm_pkg.sv =====
`timescale 1ns / 1ps
package spwm_pkg;

	localparam int NUM_CHANNELS_DEF = 2;
	localparam int TICK_WIDTH_DEF   = 16;

	localparam int ANGLE_W = 16;
	localparam int PULSE_W = 16;
	localparam int DEG_W   = 8;
	localparam int CFG_W   = 16;
	localparam int CIDX_W  = 2;
	localparam int OUT_W   = 24;
	localparam int LIM_W   = 15;
	localparam int SUM_W   = 17;
	localparam int NUM_W   = 32;
	localparam int DIV_STEPS = 32;
	localparam int DCNT_W  = $clog2(DIV_STEPS);

	localparam logic [6:0] ANGLE_SCALE = 7'd100;

	localparam logic [PULSE_W-1:0] PULSE_MIN_RST  = 16'd405;
	localparam logic [PULSE_W-1:0] PULSE_MAX_RST  = 16'd2595;
	localparam logic [DEG_W-1:0]   MAX_ANGLE_RST  = 8'd135;
	localparam logic [CFG_W-1:0]   PERIOD_RST     = 16'd20000;
	localparam logic [PULSE_W-1:0] CMP_RST_CH1    = 16'd1986;
	localparam logic [PULSE_W-1:0] CMP_RST_OTHER  = 16'd1500;

	typedef enum logic [CIDX_W-1:0] {
		REG_PULSE_MIN = 2'd0,
		REG_PULSE_MAX = 2'd1,
		REG_MAX_ANGLE = 2'd2,
		REG_PERIOD    = 2'd3
	} reg_idx_t;

	localparam logic OP_TICK  = 1'b0;
	localparam logic OP_ANGLE = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL1,
		ST_MUL2,
		ST_SUM,
		ST_DIV,
		ST_WB
	} state_t;

	typedef struct packed {
		logic tick;
		logic load;
		logic mul1;
		logic mul2;
		logic sum;
		logic div_step;
		logic wb;
	} cmd_t;

	typedef struct packed {
		logic m_zero;
		logic div_last;
	} sts_t;

endpackage

// ===== sv/servo_pwm_two_channel.sv =====
`timescale 1ns / 1ps
// Tick: result registered at the accepting edge, offered from the next cycle; ticks are
// taken back to back, one per cycle, while the result side keeps up.
// Set-angle: result registered after MUL1, MUL2 and SUM (multiply/add), a one-bit-per-cycle
// restoring divider and one write-back, which waits for the result side; if the angle limit is 0,
// MUL1 goes straight to write-back. No new item is taken before the write-back.
// Reset (arst_n low, asynchronous): counter 0, levels and m_tvalid low, compares 1500/1986, config defaults.
module servo_pwm_two_channel #(
	parameter int NUM_CHANNELS = spwm_pkg::NUM_CHANNELS_DEF,
	parameter int TICK_WIDTH   = spwm_pkg::TICK_WIDTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [spwm_pkg::ANGLE_W-1:0] s_tdata,  // [15:0] angle_centideg
	input  logic [1:0]                  s_tuser,  // [0] operation, [1] channel
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [spwm_pkg::OUT_W-1:0]  m_tdata,  // [0] pwm_level_0, [1] pwm_level_1,
	                                              // [2] frame_start, [18:3] pulse_ticks
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [spwm_pkg::CIDX_W-1:0] cfg_index,
	input  logic [spwm_pkg::CFG_W-1:0]  cfg_data
);
	import spwm_pkg::*;

	cmd_t cmd;
	sts_t sts;

	assign cfg_ready = 1'b1;

	spwm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_op     (s_tuser[0]),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd),
		.sts      (sts)
	);

	spwm_dp #(
		.NUM_CHANNELS (NUM_CHANNELS),
		.TICK_WIDTH   (TICK_WIDTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_ch     (s_tuser[1]),
		.in_angle  ($signed(s_tdata)),
		.cmd       (cmd),
		.sts       (sts),
		.res       (m_tdata)
	);

endmodule

// ===== sv/spwm_ctrl.sv =====
`timescale 1ns / 1ps
module spwm_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	input  logic              s_op,
	output logic              s_tready,
	output logic              m_tvalid,
	input  logic              m_tready,
	output spwm_pkg::cmd_t    cmd,
	input  spwm_pkg::sts_t    sts
);
	import spwm_pkg::*;

	state_t state_q, state_nxt;
	logic   out_valid_q;
	logic   out_free;
	logic   accept;

	assign out_free = !out_valid_q || m_tready;
	assign s_tready = (state_q == ST_IDLE) && out_free;
	assign accept   = s_tvalid && s_tready;
	assign m_tvalid = out_valid_q;

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: if (accept && s_op == OP_ANGLE) state_nxt = ST_MUL1;
			ST_MUL1: state_nxt = sts.m_zero ? ST_WB : ST_MUL2;
			ST_MUL2: state_nxt = ST_SUM;
			ST_SUM:  state_nxt = ST_DIV;
			ST_DIV:  if (sts.div_last) state_nxt = ST_WB;
			ST_WB:   if (out_free) state_nxt = ST_IDLE;
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd          = '0;
		cmd.tick     = accept && s_op == OP_TICK;
		cmd.load     = accept && s_op == OP_ANGLE;
		cmd.mul1     = state_q == ST_MUL1;
		cmd.mul2     = state_q == ST_MUL2;
		cmd.sum      = state_q == ST_SUM;
		cmd.div_step = state_q == ST_DIV;
		cmd.wb       = (state_q == ST_WB) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.tick || cmd.wb) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> state_q == ST_IDLE)
		else $error("input taken outside idle");

	a_div_to_wb: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV && sts.div_last) |=> state_q == ST_WB)
		else $error("divide did not end in write-back");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.tick || cmd.wb) |-> (!out_valid_q || m_tready))
		else $error("result register overwritten");

	a_one_writer: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.tick && cmd.wb))
		else $error("tick and write-back in one cycle");

endmodule

// ===== sv/spwm_dp.sv =====
`timescale 1ns / 1ps
module spwm_dp #(
	parameter int NUM_CHANNELS = spwm_pkg::NUM_CHANNELS_DEF,
	parameter int TICK_WIDTH   = spwm_pkg::TICK_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [spwm_pkg::CIDX_W-1:0]   cfg_index,
	input  logic [spwm_pkg::CFG_W-1:0]    cfg_data,
	input  logic                          in_ch,
	input  logic signed [spwm_pkg::ANGLE_W-1:0] in_angle,
	input  spwm_pkg::cmd_t                cmd,
	output spwm_pkg::sts_t                sts,
	output logic [spwm_pkg::OUT_W-1:0]    res
);
	import spwm_pkg::*;

	localparam int CMP_W = (TICK_WIDTH > PULSE_W) ? TICK_WIDTH : PULSE_W;
	localparam int CH_IW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

	logic [PULSE_W-1:0] pmin_q, pmax_q;
	logic [DEG_W-1:0]   mang_q;
	logic [CFG_W-1:0]   period_q;

	logic [TICK_WIDTH-1:0] fc_q;
	logic [PULSE_W-1:0]    shadow_q [NUM_CHANNELS];
	logic [PULSE_W-1:0]    active_q [NUM_CHANNELS];
	logic [NUM_CHANNELS-1:0] lvl_q;

	logic                       ch_q;
	logic signed [ANGLE_W-1:0]  cd_q;
	logic [LIM_W-1:0]           lim_q;
	logic [SUM_W-1:0]           sum_q;
	logic signed [SUM_W-1:0]    diff_q;
	logic                       mzero_q;
	logic [NUM_W-1:0]           p1_q;
	logic signed [ANGLE_W+SUM_W-1:0] p2_q;
	logic [NUM_W-1:0]           quo_q;
	logic [PULSE_W-1:0]         rem_q;
	logic [LIM_W:0]             dvs_q;
	logic [DCNT_W-1:0]          dcnt_q;
	logic [OUT_W-1:0]           res_q;

	logic [TICK_WIDTH-1:0]   fc_inc, fc_nxt;
	logic                    fs;
	logic [NUM_CHANNELS-1:0] lvl_nxt;
	logic [NUM_CHANNELS:0]   lvl_ext;
	logic signed [ANGLE_W:0] cd_x, lim_x;
	logic signed [ANGLE_W-1:0] cd_c;
	logic signed [NUM_W+1:0] num_x;
	logic [PULSE_W:0]        trial;
	logic                    qbit;
	logic [PULSE_W-1:0]      pulse;

	// frame counter: advance, wrap at the period
	always_comb begin
		fc_inc = fc_q + 1'b1;
		fc_nxt = (CMP_W'(fc_inc) >= CMP_W'(period_q)) ? '0 : fc_inc;
		fs     = fc_nxt == '0;
		for (int i = 0; i < NUM_CHANNELS; i++) begin
			lvl_nxt[i] = fs ? 1'b1 : lvl_q[i];
			if (CMP_W'(fc_nxt) == CMP_W'(fs ? shadow_q[i] : active_q[i])) begin
				lvl_nxt[i] = 1'b0;
			end
		end
	end

	// clamp to +/- limit
	always_comb begin
		cd_x  = (ANGLE_W+1)'(cd_q);
		lim_x = $signed({2'b00, lim_q});
		if (cd_x < -lim_x) begin
			cd_c = ANGLE_W'(-lim_x);
		end else if (cd_x > lim_x) begin
			cd_c = ANGLE_W'(lim_x);
		end else begin
			cd_c = cd_q;
		end
	end

	assign num_x = $signed({2'b00, p1_q}) + (NUM_W+2)'(p2_q);

	// one restoring divide step per cycle
	always_comb begin
		trial = {rem_q, quo_q[NUM_W-1]};
		qbit  = trial >= (PULSE_W+1)'(dvs_q);
	end

	assign pulse   = mzero_q ? sum_q[SUM_W-1:1] : quo_q[PULSE_W-1:0];
	assign lvl_ext = {1'b0, lvl_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pmin_q   <= PULSE_MIN_RST;
			pmax_q   <= PULSE_MAX_RST;
			mang_q   <= MAX_ANGLE_RST;
			period_q <= PERIOD_RST;
			fc_q     <= '0;
			lvl_q    <= '0;
			for (int i = 0; i < NUM_CHANNELS; i++) begin
				shadow_q[i] <= (i == 1) ? CMP_RST_CH1 : CMP_RST_OTHER;
				active_q[i] <= (i == 1) ? CMP_RST_CH1 : CMP_RST_OTHER;
			end
		end else begin
			if (cfg_we) begin
				unique case (reg_idx_t'(cfg_index))
					REG_PULSE_MIN: pmin_q   <= cfg_data;
					REG_PULSE_MAX: pmax_q   <= cfg_data;
					REG_MAX_ANGLE: mang_q   <= cfg_data[DEG_W-1:0];
					REG_PERIOD:    period_q <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.tick) begin
				fc_q  <= fc_nxt;
				lvl_q <= lvl_nxt;
				if (fs) begin
					for (int i = 0; i < NUM_CHANNELS; i++) begin
						active_q[i] <= shadow_q[i];
					end
				end
			end
			if (cmd.wb && 32'(ch_q) < NUM_CHANNELS) begin
				shadow_q[CH_IW'(ch_q)] <= pulse;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			ch_q    <= in_ch;
			cd_q    <= in_angle;
			lim_q   <= LIM_W'(mang_q) * LIM_W'(ANGLE_SCALE);
			sum_q   <= SUM_W'(pmin_q) + SUM_W'(pmax_q);
			diff_q  <= $signed(SUM_W'(pmax_q) - SUM_W'(pmin_q));
			mzero_q <= mang_q == '0;
		end
		if (cmd.mul1) begin
			p1_q <= NUM_W'(lim_q) * NUM_W'(sum_q);
		end
		if (cmd.mul2) begin
			p2_q <= (ANGLE_W+SUM_W)'(cd_c) * (ANGLE_W+SUM_W)'(diff_q);
		end
		if (cmd.sum) begin
			quo_q  <= num_x[NUM_W-1:0];
			rem_q  <= '0;
			dvs_q  <= {lim_q, 1'b0};
			dcnt_q <= '0;
		end
		if (cmd.div_step) begin
			rem_q  <= qbit ? PULSE_W'(trial - (PULSE_W+1)'(dvs_q)) : trial[PULSE_W-1:0];
			quo_q  <= {quo_q[NUM_W-2:0], qbit};
			dcnt_q <= dcnt_q + 1'b1;
		end
		if (cmd.tick) begin
			res_q <= {{(OUT_W-PULSE_W-3){1'b0}}, {PULSE_W{1'b0}}, fs,
				(NUM_CHANNELS > 1) ? lvl_nxt[NUM_CHANNELS > 1 ? 1 : 0] : 1'b0,
				lvl_nxt[0]};
		end else if (cmd.wb) begin
			res_q <= {{(OUT_W-PULSE_W-3){1'b0}}, pulse, 1'b0, lvl_ext[1], lvl_q[0]};
		end
	end

	assign sts.m_zero   = mzero_q;
	assign sts.div_last = dcnt_q == DCNT_W'(DIV_STEPS - 1);
	assign res          = res_q;

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
	import spwm_pkg::*;

	localparam int CYCLE_LIMIT = 400_000;
	localparam int HOLDOFF_CYCLES = 300;

	typedef struct packed {
		logic [PULSE_W-1:0] pulse_ticks;
		logic               frame_start;
		logic               level_1;
		logic               level_0;
	} servo_result_t;

	// Tracks counter, compares and levels of both channels, and the results still owed.
	class servo_scoreboard;
		logic [PULSE_W-1:0] pulse_min, pulse_max, period;
		logic [DEG_W-1:0]   angle_limit;
		logic [PULSE_W-1:0] counter;
		logic [PULSE_W-1:0] shadow_cmp[2];
		logic [PULSE_W-1:0] active_cmp[2];
		logic               level[2];
		servo_result_t      expected_q[$];
		int                 failures;

		function new();
			pulse_min   = PULSE_MIN_RST;
			pulse_max   = PULSE_MAX_RST;
			angle_limit = MAX_ANGLE_RST;
			period      = PERIOD_RST;
			counter     = '0;
			failures    = 0;
			for (int c = 0; c < 2; c++) begin
				shadow_cmp[c] = (c == 1) ? CMP_RST_CH1 : CMP_RST_OTHER;
				active_cmp[c] = shadow_cmp[c];
				level[c]      = 1'b0;
			end
		endfunction

		function void set_reg(reg_idx_t idx, logic [CFG_W-1:0] val);
			case (idx)
				REG_PULSE_MIN: pulse_min = val;
				REG_PULSE_MAX: pulse_max = val;
				REG_MAX_ANGLE: angle_limit = val[DEG_W-1:0];
				REG_PERIOD: period = val;
				default: ;
			endcase
		endfunction

		function logic [PULSE_W-1:0] angle_to_pulse(logic signed [ANGLE_W-1:0] ang);
			longint lo, hi, span, cd, num;
			lo   = pulse_min;
			hi   = pulse_max;
			span = 100 * longint'(angle_limit);
			cd   = ang;
			if (span == 0)
				return PULSE_W'((lo + hi) / 2);
			if (cd < -span) cd = -span;
			if (cd > span) cd = span;
			num = span * (lo + hi) + cd * (hi - lo);
			if (num < 0) num = 0;
			return PULSE_W'(num / (2 * span));
		endfunction

		function void note_input(logic op, logic ch, logic [ANGLE_W-1:0] ang);
			servo_result_t res;
			res = '0;
			if (op == OP_ANGLE) begin
				res.pulse_ticks = angle_to_pulse(ang);
				shadow_cmp[ch] = res.pulse_ticks;
			end else begin
				counter = counter + 1'b1;
				if (counter >= period)
					counter = '0;
				if (counter == 0) begin
					res.frame_start = 1'b1;
					for (int c = 0; c < 2; c++) begin
						active_cmp[c] = shadow_cmp[c];
						level[c]      = 1'b1;
					end
				end
				// match wins over the frame-start set
				for (int c = 0; c < 2; c++)
					if (counter == active_cmp[c])
						level[c] = 1'b0;
			end
			res.level_0 = level[0];
			res.level_1 = level[1];
			expected_q.push_back(res);
		endfunction

		function void check_result(logic [OUT_W-1:0] data);
			servo_result_t got, want;
			got = servo_result_t'(data[$bits(servo_result_t)-1:0]);
			if (expected_q.size() == 0) begin
				failures++;
				if (failures <= 10)
					$display("%0t: result %h arrived with nothing pending", $realtime, data);
				return;
			end
			want = expected_q.pop_front();
			if (got !== want) begin
				failures++;
				if (failures <= 10)
					$display("%0t: expected lvl0=%b lvl1=%b start=%b pulse=%0d, got lvl0=%b lvl1=%b start=%b pulse=%0d",
						$realtime, want.level_0, want.level_1, want.frame_start, want.pulse_ticks,
						got.level_0, got.level_1, got.frame_start, got.pulse_ticks);
			end
		endfunction

		function int pending();
			return expected_q.size();
		endfunction
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [ANGLE_W-1:0]   s_tdata = '0;
	logic [1:0]           s_tuser = '0;   // [0] operation, [1] channel
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [OUT_W-1:0]     m_tdata;        // [0] level 0, [1] level 1, [2] frame start, [18:3] pulse
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	reg_idx_t             cfg_index = REG_PULSE_MIN;
	logic [CFG_W-1:0]     cfg_data = '0;

	servo_scoreboard sb = new();
	bit steady = 1'b0;
	int holdoff_requests = 0;
	int holdoffs_served = 0;
	int stall_left = 0;
	int cycles = 0;

	servo_pwm_two_channel dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// Result side: check each transaction, then choose the next ready level.
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready)
				sb.check_result(m_tdata);
			if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else if (holdoffs_served != holdoff_requests) begin
				holdoffs_served = holdoff_requests;
				stall_left = HOLDOFF_CYCLES;
				m_tready <= 1'b0;
			end else begin
				m_tready <= steady || ($urandom_range(99) >= 20);
			end
		end
	end

	task automatic send_item(input logic op, input logic ch, input logic [ANGLE_W-1:0] ang);
		while (!steady && $urandom_range(99) < 20) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= {ch, op};
		s_tdata  <= ang;
		do @(posedge clk); while (!s_tready);
		sb.note_input(op, ch, ang);
	endtask

	// Hold the input until every owed result has come back.
	task automatic settle();
		s_tvalid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic program_regs(input logic [CFG_W-1:0] lo_us, input logic [CFG_W-1:0] hi_us,
			input logic [DEG_W-1:0] lim_deg, input logic [CFG_W-1:0] per);
		reg_idx_t idx;
		logic [CFG_W-1:0] val;
		for (int r = 0; r < 4; r++) begin
			idx = reg_idx_t'(r);
			case (idx)
				REG_PULSE_MIN: val = lo_us;
				REG_PULSE_MAX: val = hi_us;
				REG_MAX_ANGLE: val = CFG_W'(lim_deg);
				default: val = per;
			endcase
			cfg_valid <= 1'b1;
			cfg_index <= idx;
			cfg_data  <= val;
			do @(posedge clk); while (!cfg_ready);
			sb.set_reg(idx, val);
		end
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [ANGLE_W-1:0] pick_angle(logic [DEG_W-1:0] lim);
		int unsigned span;
		int unsigned sel;
		span = 100 * lim;
		sel  = $urandom_range(9);
		if (sel < 5)
			return ANGLE_W'($urandom_range(2 * span) - span);
		if (sel < 8)
			return ANGLE_W'($urandom);
		case ($urandom_range(2))
			0: return ANGLE_W'(span);
			1: return ANGLE_W'(-span);
			default: return '0;
		endcase
	endfunction

	initial begin
		logic [CFG_W-1:0] lo;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// levels stay low until the first frame starts
		send_item(OP_TICK, 1'b0, 16'h0000);
		send_item(OP_TICK, 1'b1, 16'hFFFF);
		send_item(OP_ANGLE, 1'b0, 16'h8000);
		send_item(OP_ANGLE, 1'b1, 16'h7FFF);
		send_item(OP_ANGLE, 1'b0, 16'h0000);
		send_item(OP_ANGLE, 1'b1, 16'hCB44);

		// zero compare keeps channel 0 low, compare past the period keeps channel 1 high
		settle();
		program_regs(16'd0, 16'd40, 8'd1, 16'd4);
		send_item(OP_ANGLE, 1'b0, 16'hFF9C);
		send_item(OP_ANGLE, 1'b1, 16'd100);
		repeat (5) send_item(OP_TICK, 1'b0, 16'h0000);

		// drop the period under the running count, next tick must wrap
		settle();
		program_regs(16'd3, 16'd9, 8'd180, 16'd40);
		repeat (8) send_item(OP_TICK, 1'b1, 16'h0000);
		settle();
		program_regs(16'd3, 16'd9, 8'd180, 16'd6);
		send_item(OP_TICK, 1'b0, 16'h0000);

		// maximum below minimum, zero period
		settle();
		program_regs(16'hFFFF, 16'd0, 8'd180, 16'd0);
		send_item(OP_ANGLE, 1'b0, 16'd18000);
		send_item(OP_ANGLE, 1'b1, -16'sd18000);
		send_item(OP_TICK, 1'b0, 16'h0000);
		send_item(OP_TICK, 1'b0, 16'h0000);

		// zero angle limit gives the midpoint
		settle();
		program_regs(16'hFFFF, 16'd0, 8'd0, 16'd0);
		send_item(OP_ANGLE, 1'b0, 16'd1);
		send_item(OP_TICK, 1'b1, 16'h0000);

		for (int ph = 0; ph < 8; ph++) begin
			settle();
			case (ph)
				0: program_regs(16'd0, 16'hFFFF, 8'd180, 16'd1);
				1: program_regs(16'hFFFF, 16'hFFFF, 8'd1, 16'hFFFF);
				2: program_regs(CFG_W'($urandom), CFG_W'($urandom), DEG_W'($urandom_range(1, 180)),
					CFG_W'($urandom_range(2, 200)));
				default: begin
					lo = CFG_W'($urandom_range(0, 30));
					program_regs(lo, lo + CFG_W'($urandom_range(0, 80)),
						DEG_W'($urandom_range(1, 180)), CFG_W'($urandom_range(1, 120)));
				end
			endcase
			steady = (ph == 3);
			for (int n = 0; n < 84; n++) begin
				if (ph == 5 && n == 10)
					holdoff_requests++;
				if ($urandom_range(3) == 0)
					send_item(OP_ANGLE, 1'($urandom_range(1)), pick_angle(sb.angle_limit));
				else
					send_item(OP_TICK, 1'($urandom_range(1)), ANGLE_W'($urandom));
			end
		end
		steady = 1'b0;

		s_tvalid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		if (sb.failures == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
